// File: rtl/zrle_pkg.sv
// Shared types, constants and helpers for the zero-escape RLE decoder.
`timescale 1ns / 1ps

package zrle_pkg;

   localparam int unsigned MaxCapacityDefault = 65536;
   localparam int unsigned OutBytesDefault    = 8;

   localparam int unsigned CapW   = 17;
   localparam int unsigned DataW  = 64;
   localparam int unsigned CountW = 4;
   localparam int unsigned LaneN  = DataW / 8;

   localparam logic [CapW-1:0] CapReset = CapW'(4096);

   localparam logic KindData   = 1'b0;
   localparam logic KindStatus = 1'b1;

   localparam logic StatusOk    = 1'b0;
   localparam logic StatusError = 1'b1;

   typedef enum logic [1:0] {
      PH_PLAIN = 2'd0,
      PH_COUNT = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EMIT   = 2'd1,
      ST_STATUS = 2'd2
   } seq_state_type;

   // one result as it leaves the sequencer
   typedef struct packed {
      logic              kind;
      logic [DataW-1:0]  data;
      logic [CountW-1:0] count;
      logic              status;
      logic [CapW-1:0]   length;
      logic              last;
   } result_type;

   // outputs of the shared step unit
   typedef struct packed {
      logic [CountW-1:0] chunk;
      logic [7:0]        rem_next;
      logic [CapW-1:0]   space_next;
      logic [CapW-1:0]   produced_next;
      logic [DataW-1:0]  word;
   } step_type;

   function automatic logic [CapW-1:0] clamp_cap(input logic [CapW-1:0] v,
                                                 input int unsigned max_cap);
      logic [CapW-1:0] r;
      if (32'(v) > max_cap) begin
         r = CapW'(max_cap);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: rtl/zrle_step_unit.sv
// Shared step unit: one packed chunk of a run, with count and space bookkeeping.
`timescale 1ns / 1ps

module zrle_step_unit
   import zrle_pkg::*;
#(
   parameter int unsigned OUT_BYTES = OutBytesDefault
) (
   input  logic [7:0]      rem,
   input  logic [7:0]      value,
   input  logic [CapW-1:0] space,
   input  logic [CapW-1:0] produced,
   output step_type        step
);

   localparam logic [CountW-1:0] ChunkMax = CountW'(OUT_BYTES);

   logic [CountW-1:0] chunk;

   always_comb begin
      if (rem > 8'(ChunkMax)) begin
         chunk = ChunkMax;
      end else begin
         chunk = CountW'(rem);
      end
   end

   always_comb begin
      step.chunk         = chunk;
      step.rem_next      = rem - 8'(chunk);
      step.space_next    = space - CapW'(chunk);
      step.produced_next = produced + CapW'(chunk);
      for (int i = 0; i < LaneN; i++) begin
         step.word[i*8 +: 8] = (CountW'(i) < chunk) ? value : 8'h00;
      end
   end

endmodule

// File: rtl/zrle_seq.sv
// Decode sequencer: escape/count/value parsing and run emission control.
`timescale 1ns / 1ps

module zrle_seq
   import zrle_pkg::*;
#(
   parameter int unsigned MAX_CAPACITY = MaxCapacityDefault,
   parameter int unsigned OUT_BYTES    = OutBytesDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      in_byte,
   input  logic            end_of_input,
   input  logic [CapW-1:0] capacity,
   output logic            item_valid,
   input  logic            item_take,
   output result_type      item
);

   seq_state_type   state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic [7:0]      run_count_ff, run_count_in;
   logic [CapW-1:0] space_ff, space_in;
   logic [CapW-1:0] produced_ff, produced_in;
   logic            error_ff, error_in;
   logic [7:0]      rem_ff, rem_in;
   logic [7:0]      value_ff, value_in;
   logic            status_pend_ff, status_pend_in;

   logic            accept;
   logic [7:0]      dec_n;
   logic [7:0]      dec_val;
   logic            dec_err;
   phase_type       dec_phase;
   logic [7:0]      dec_run;
   step_type        step;

   assign accept = req_valid && (state_ff == ST_IDLE);

   zrle_step_unit #(
      .OUT_BYTES(OUT_BYTES)
   ) u_step (
      .rem     (rem_ff),
      .value   (value_ff),
      .space   (space_ff),
      .produced(produced_ff),
      .step    (step)
   );

   // decode of one source byte against the current phase
   always_comb begin
      dec_n     = 8'd0;
      dec_val   = in_byte;
      dec_err   = 1'b0;
      dec_phase = phase_ff;
      dec_run   = run_count_ff;
      if (!error_ff) begin
         unique case (phase_ff)
            PH_COUNT: begin
               if (in_byte == 8'd0) begin
                  // escaped zero
                  if (space_ff == '0) begin
                     dec_err = 1'b1;
                  end else begin
                     dec_n = 8'd1;
                  end
                  dec_phase = PH_PLAIN;
               end else if (space_ff < CapW'(in_byte)) begin
                  dec_err = 1'b1;
               end else if (end_of_input) begin
                  dec_err = 1'b1;
               end else begin
                  dec_run   = in_byte;
                  dec_phase = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (CapW'(run_count_ff) <= space_ff) begin
                  dec_n = run_count_ff;
               end else begin
                  dec_err = 1'b1;
               end
               dec_run   = 8'd0;
               dec_phase = PH_PLAIN;
            end
            default: begin
               if (in_byte != 8'd0) begin
                  if (space_ff == '0) begin
                     dec_err = 1'b1;
                  end else begin
                     dec_n = 8'd1;
                  end
               end else if (end_of_input) begin
                  dec_err = 1'b1;
               end else begin
                  dec_phase = PH_COUNT;
               end
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (dec_n != 8'd0) begin
                  state_in = ST_EMIT;
               end else if (end_of_input) begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_EMIT: begin
            if (item_take && (step.rem_next == 8'd0)) begin
               state_in = status_pend_ff ? ST_STATUS : ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (item_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      phase_in       = phase_ff;
      run_count_in   = run_count_ff;
      space_in       = space_ff;
      produced_in    = produced_ff;
      error_in       = error_ff;
      rem_in         = rem_ff;
      value_in       = value_ff;
      status_pend_in = status_pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               phase_in       = dec_phase;
               run_count_in   = dec_run;
               error_in       = error_ff | dec_err;
               rem_in         = dec_n;
               value_in       = dec_val;
               status_pend_in = end_of_input;
            end
         end
         ST_EMIT: begin
            if (item_take) begin
               rem_in      = step.rem_next;
               space_in    = step.space_next;
               produced_in = step.produced_next;
            end
         end
         ST_STATUS: begin
            if (item_take) begin
               // packet closed: re-arm
               phase_in       = PH_PLAIN;
               run_count_in   = 8'd0;
               space_in       = clamp_cap(capacity, MAX_CAPACITY);
               produced_in    = '0;
               error_in       = 1'b0;
               status_pend_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      item_valid  = (state_ff == ST_EMIT) || (state_ff == ST_STATUS);
      item.kind   = KindData;
      item.data   = step.word;
      item.count  = step.chunk;
      item.status = StatusOk;
      item.length = '0;
      item.last   = (step.rem_next == 8'd0) && !status_pend_ff;
      if (state_ff == ST_STATUS) begin
         item.kind   = KindStatus;
         item.data   = '0;
         item.count  = '0;
         item.status = error_ff ? StatusError : StatusOk;
         item.length = produced_ff;
         item.last   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_PLAIN;
         run_count_ff   <= 8'd0;
         space_ff       <= clamp_cap(CapReset, MAX_CAPACITY);
         produced_ff    <= '0;
         error_ff       <= 1'b0;
         rem_ff         <= 8'd0;
         status_pend_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         run_count_ff   <= run_count_in;
         space_ff       <= space_in;
         produced_ff    <= produced_in;
         error_ff       <= error_in;
         rem_ff         <= rem_in;
         status_pend_ff <= status_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: rtl/zero_escape_rle_decoder_core.sv
// A request is taken only while the sequencer is idle; each result then passes through one output register.
// A byte with no output leaves the sequencer idle; a literal or a run is emitted in chunks of up to OUT_BYTES
// bytes set by the shared step unit, and the closing byte of a packet adds its status result.
// Stalls on rsp_ready hold the sequencer; req_ready is high only while it is idle.
// Reset (synchronous, active high): capacity 4096, decoder re-armed, output register empty.
`timescale 1ns / 1ps

module zero_escape_rle_decoder_core
   import zrle_pkg::*;
#(
   parameter int unsigned MAX_CAPACITY = MaxCapacityDefault,
   parameter int unsigned OUT_BYTES    = OutBytesDefault
) (
   input  logic              clock,
   input  logic              reset,
   // capacity register
   input  logic              csr_wr_en,
   input  logic [CapW-1:0]   csr_wr_data,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_input,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_result_kind,
   output logic [DataW-1:0]  rsp_out_data,
   output logic [CountW-1:0] rsp_byte_count,
   output logic              rsp_status_code,
   output logic [CapW-1:0]   rsp_produced_length,
   output logic              rsp_last_of_run
);

   logic [CapW-1:0] cap_ff, cap_in;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_item_ff, rsp_item_in;

   logic            item_valid;
   result_type      item;
   logic            out_free;

   // capacity only reaches the decoder at the next packet start
   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   // output register frees when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   zrle_seq #(
      .MAX_CAPACITY(MAX_CAPACITY),
      .OUT_BYTES   (OUT_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .in_byte     (req_in_byte),
      .end_of_input(req_end_of_input),
      .capacity    (cap_ff),
      .item_valid  (item_valid),
      .item_take   (out_free),
      .item        (item)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_free) begin
         rsp_valid_in = item_valid;
         rsp_item_in  = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CapReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_item_ff.kind;
   assign rsp_out_data        = rsp_item_ff.data;
   assign rsp_byte_count      = rsp_item_ff.count;
   assign rsp_status_code     = rsp_item_ff.status;
   assign rsp_produced_length = rsp_item_ff.length;
   assign rsp_last_of_run     = rsp_item_ff.last;

`ifndef SYNTHESIS
   // a data result always carries between one and OUT_BYTES bytes
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KindData)) |->
         ((rsp_byte_count != '0) && (rsp_byte_count <= CountW'(OUT_BYTES))))
      else $error("data result with bad byte count");

   // a status result closes its request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KindStatus)) |-> rsp_last_of_run)
      else $error("status result not marked last");

   // the closing request of a packet always owes a status, so no new request follows at once
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_input) |=> !req_ready)
      else $error("ready after end of packet request");
`endif

endmodule

// File: tb/sv/rle_expand_checker.sv
// Watches the request and result channels, predicts the expanded output and compares it.
`timescale 1ns / 1ps

module rle_expand_checker
   import zrle_pkg::*;
#(
   parameter int unsigned MAX_CAPACITY = MaxCapacityDefault,
   parameter int unsigned OUT_BYTES    = OutBytesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CapW-1:0]   csr_wr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_input,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_result_kind,
   input  logic [DataW-1:0]  rsp_out_data,
   input  logic [CountW-1:0] rsp_byte_count,
   input  logic              rsp_status_code,
   input  logic [CapW-1:0]   rsp_produced_length,
   input  logic              rsp_last_of_run,
   output int                fail_count,
   output int                pending
);

   result_type      expansion_q[$];
   logic [CapW-1:0] cap_reg;
   logic [CapW-1:0] room;
   logic [CapW-1:0] made;
   phase_type       phase;
   logic [7:0]      run_len;
   logic            err_seen;
   logic            field_bad;

   // capacity is sampled into room only here, so a write counts from the packet after
   task automatic rearm();
      phase    = PH_PLAIN;
      run_len  = '0;
      err_seen = 1'b0;
      made     = '0;
      if (32'(cap_reg) > MAX_CAPACITY) begin
         room = CapW'(MAX_CAPACITY);
      end else begin
         room = cap_reg;
      end
   endtask

   task automatic emit(input logic [7:0] value, input int n);
      result_type r;
      int         chunk;
      while (n > 0) begin
         chunk = (n > int'(OUT_BYTES)) ? int'(OUT_BYTES) : n;
         r = '0;
         r.kind   = KindData;
         r.status = StatusOk;
         r.count  = CountW'(chunk);
         for (int i = 0; i < chunk; i++) begin
            r.data[8*i +: 8] = value;
         end
         expansion_q.push_back(r);
         room -= CapW'(chunk);
         made += CapW'(chunk);
         n    -= chunk;
      end
   endtask

   task automatic expand_byte(input logic [7:0] b, input logic eop);
      int         n_before;
      result_type r;
      n_before = expansion_q.size();
      if (!err_seen) begin
         case (phase)
            PH_COUNT: begin
               if (b == 8'd0) begin
                  if (room == '0) err_seen = 1'b1;
                  else emit(8'd0, 1);
                  phase = PH_PLAIN;
               end else if (room < CapW'(b)) begin
                  err_seen = 1'b1;
               end else if (eop) begin
                  err_seen = 1'b1;
               end else begin
                  run_len = b;
                  phase   = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (CapW'(run_len) <= room) emit(b, int'(run_len));
               else err_seen = 1'b1;
               run_len = '0;
               phase   = PH_PLAIN;
            end
            default: begin
               if (b != 8'd0) begin
                  if (room == '0) err_seen = 1'b1;
                  else emit(b, 1);
               end else if (eop) begin
                  err_seen = 1'b1;
               end else begin
                  phase = PH_COUNT;
               end
            end
         endcase
      end
      if (eop) begin
         r = '0;
         r.kind   = KindStatus;
         r.status = err_seen ? StatusError : StatusOk;
         r.length = made;
         expansion_q.push_back(r);
         rearm();
      end
      if (expansion_q.size() > n_before) begin
         expansion_q[expansion_q.size()-1].last = 1'b1;
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         field_bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cap_reg = CapReset;
         rearm();
         expansion_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expansion_q.size() == 0) begin
               $display("%0t: result with nothing due, expected none, actual kind %0b data %0h",
                        $time, rsp_result_kind, rsp_out_data);
               fail_count++;
            end else begin
               want      = expansion_q.pop_front();
               field_bad = 1'b0;
               check_field("result_kind", 64'(want.kind), 64'(rsp_result_kind));
               check_field("out_data", want.data, rsp_out_data);
               check_field("byte_count", 64'(want.count), 64'(rsp_byte_count));
               check_field("status_code", 64'(want.status), 64'(rsp_status_code));
               check_field("produced_length", 64'(want.length), 64'(rsp_produced_length));
               check_field("last_of_run", 64'(want.last), 64'(rsp_last_of_run));
               if (field_bad) fail_count++;
            end
         end
         if (csr_wr_en) cap_reg = csr_wr_data;
         if (req_valid && req_ready) expand_byte(req_in_byte, req_end_of_input);
      end
      pending = expansion_q.size();
   end

endmodule

// File: tb/sv/zero_escape_rle_decoder_core_tb.sv
// Stimulus, handshake pacing and verdict for the zero-escape RLE decoder core.
`timescale 1ns / 1ps

module zero_escape_rle_decoder_core_tb;
   import zrle_pkg::*;

   localparam int CycleLimit = 1_000_000;
   localparam int RandItems  = 80;
   localparam int LongHold   = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [CapW-1:0]   csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_in_byte = '0;
   logic              req_end_of_input = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_result_kind;
   logic [DataW-1:0]  rsp_out_data;
   logic [CountW-1:0] rsp_byte_count;
   logic              rsp_status_code;
   logic [CapW-1:0]   rsp_produced_length;
   logic              rsp_last_of_run;

   int         fail_count;
   int         pending;
   int         cycles = 0;
   bit         idle_on = 1'b1;   // both sides insert random gaps while set
   bit         hold_long = 1'b0; // asks the receiver for one long stall
   logic [7:0] pkt_q[$];         // compressed bytes of the packet being sent

   zero_escape_rle_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_data       (rsp_out_data),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_status_code    (rsp_status_code),
      .rsp_produced_length(rsp_produced_length),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   rle_expand_checker u_check (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_data       (rsp_out_data),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_status_code    (rsp_status_code),
      .rsp_produced_length(rsp_produced_length),
      .rsp_last_of_run    (rsp_last_of_run),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: per result a random stall, plus one long
   // hold-off on request so that the core backs up and drops req_ready.
   initial begin : receiver
      int wait_n;
      @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (LongHold) @(negedge clock);
            hold_long = 1'b0;
         end
         wait_n = idle_on ? $urandom_range(0, 12) : 0;
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Offers one request and returns on the falling edge after it is taken.
   // valid is left high so that a back-to-back request keeps it up.
   task automatic send_byte(input logic [7:0] b, input logic eop);
      int gap;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_end_of_input <= eop;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // the whole packet in pkt_q, end_of_input on its last byte
   task automatic send_packet();
      for (int i = 0; i < pkt_q.size(); i++) begin
         send_byte(pkt_q[i], i == pkt_q.size() - 1);
      end
   endtask

   // Waits for every predicted result, then waits on for a request
   // that makes no result to settle, so the core is idle afterwards.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CapW-1:0] v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random packet: mostly well-formed token streams, some noise and some
   // endings cut short after an escape or a count.
   task automatic make_packet();
      int ntok;
      int sel;
      ntok = $urandom_range(1, 10);
      pkt_q.delete();
      if ($urandom_range(0, 9) < 2) begin
         repeat (ntok + 2) begin
            pkt_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
         end
      end else begin
         repeat (ntok) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
               pkt_q.push_back(8'($urandom_range(1, 255)));
            end else if (sel == 5) begin
               pkt_q.push_back(8'h00);
               pkt_q.push_back(8'h00);
            end else begin
               pkt_q.push_back(8'h00);
               pkt_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                           : 8'($urandom_range(1, 20)));
               pkt_q.push_back(8'($urandom_range(0, 255)));
            end
         end
         sel = $urandom_range(0, 11);
         if (sel == 0) begin
            pkt_q.push_back(8'h00);
         end else if (sel == 1) begin
            pkt_q.push_back(8'h00);
            pkt_q.push_back(8'($urandom_range(1, 255)));
         end
      end
   endtask

   initial begin : stimulus
      logic [CapW-1:0] cap_list[$];
      int              rand_items;
      int              phase_items;
      int              pick;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset capacity: literals at both ends, literal zero,
      // short run, longest run (32 data words) and a closing literal.
      pkt_q = '{8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h05, 8'hAA,
                8'h00, 8'hFF, 8'h55, 8'h80};
      send_packet();
      pkt_q = '{8'h00};                 // packet ends on an escape
      send_packet();
      pkt_q = '{8'h00, 8'h07};          // packet ends on a nonzero count
      send_packet();
      pkt_q = '{8'h00, 8'h00};          // literal zero as the final byte
      send_packet();
      drain();

      // zero capacity: this packet still runs on the old room
      write_capacity('0);
      pkt_q = '{8'h42, 8'h00, 8'h03, 8'h11};
      send_packet();
      pkt_q = '{8'h09, 8'h00, 8'h00};   // no room: literal fails, rest dropped
      send_packet();
      drain();

      // tiny capacity: a literal zero on the old zero room, then run too long, an exact fill, and overflow by a literal
      write_capacity(CapW'(3));
      pkt_q = '{8'h00, 8'h00};
      send_packet();
      pkt_q = '{8'h00, 8'h04, 8'h77, 8'h12};
      send_packet();
      pkt_q = '{8'h00, 8'h03, 8'h33};
      send_packet();
      pkt_q = '{8'h00, 8'h02, 8'h44, 8'h01, 8'h02};
      send_packet();
      drain();

      // Random part: capacity changes between phases, extremes among them.
      cap_list = '{CapW'(131071), CapW'(40), CapW'(0), CapW'(65536),
                   CapW'(9), CapW'($urandom_range(0, 131071)), CapW'(2000)};
      write_capacity(cap_list[0]);
      pick        = 1;
      rand_items  = 0;
      phase_items = 0;

      // long receiver stall behind a full run with literals queued up
      hold_long = 1'b1;
      pkt_q = '{8'h00, 8'hFF, 8'h5A, 8'h21, 8'h22, 8'h23, 8'h00, 8'h10, 8'hC3, 8'h24};
      send_packet();
      rand_items += pkt_q.size();

      while (rand_items < RandItems) begin
         idle_on = ($urandom_range(0, 3) != 0);
         make_packet();
         send_packet();
         rand_items  += pkt_q.size();
         phase_items += pkt_q.size();
         if (phase_items >= 20) begin
            drain();
            write_capacity(cap_list[pick % cap_list.size()]);
            pick++;
            phase_items = 0;
         end
      end

      drain();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: zero_escape_rle_decoder_core.f
rtl/zrle_pkg.sv
rtl/zrle_step_unit.sv
rtl/zrle_seq.sv
rtl/zero_escape_rle_decoder_core.sv
tb/sv/rle_expand_checker.sv
tb/sv/zero_escape_rle_decoder_core_tb.sv
